>>> design/v4a_pkg.sv
// shared types, opcodes and saturation helper for the 4-tuple vector alu
package v4a_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned TOL_W  = 17;
   localparam int unsigned LANES  = 4;

   typedef logic signed [WORD_W-1:0] word_type;

   localparam word_type WORD_MAX = 32'sh7FFF_FFFF;
   localparam word_type WORD_MIN = 32'sh8000_0000;

   // operation codes carried in req_type
   typedef enum logic [3:0] {
      OP_CMP     = 4'd0,
      OP_ADD     = 4'd1,
      OP_SUB     = 4'd2,
      OP_MUL     = 4'd3,
      OP_NEG     = 4'd4,
      OP_SCALE   = 4'd5,
      OP_DIV     = 4'd6,
      OP_MAG     = 4'd7,
      OP_NORM    = 4'd8,
      OP_DOT     = 4'd9,
      OP_CROSS   = 4'd10,
      OP_REFLECT = 4'd11
   } op_type;

   // per-lane state of the restoring divider
   typedef struct packed {
      logic [LANES-1:0][WORD_W-1:0] rem;
      logic [LANES-1:0][WORD_W-1:0] nlo;
      logic [LANES-1:0][WORD_W-1:0] quo;
   } div_lanes_type;

   // clamp a wide signed value to the signed word range
   function automatic word_type sat_word(input logic signed [65:0] v);
      word_type r;
      if (v > 66'sd2147483647) begin
         r = WORD_MAX;
      end else if (v < -66'sd2147483648) begin
         r = WORD_MIN;
      end else begin
         r = word_type'(v[WORD_W-1:0]);
      end
      return r;
   endfunction

endpackage

>>> design/v4a_if.sv
// request and response channel interfaces of the vector alu

interface v4a_req_if;
   logic              valid;
   logic              ready;
   logic [3:0]        req_type;
   logic signed [31:0] a_x;
   logic signed [31:0] a_y;
   logic signed [31:0] a_z;
   logic signed [31:0] a_w;
   logic signed [31:0] b_x;
   logic signed [31:0] b_y;
   logic signed [31:0] b_z;
   logic signed [31:0] b_w;
   logic signed [31:0] scalar_in;

   modport source (
      output valid, req_type, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in,
      input  ready
   );
   modport sink (
      input  valid, req_type, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in,
      output ready
   );
endinterface

interface v4a_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] r_x;
   logic signed [31:0] r_y;
   logic signed [31:0] r_z;
   logic signed [31:0] r_w;
   logic signed [31:0] r_scalar;
   logic              equal_flag;
   logic              zero_divisor;

   modport source (
      output valid, r_x, r_y, r_z, r_w, r_scalar, equal_flag, zero_divisor,
      input  ready
   );
   modport sink (
      input  valid, r_x, r_y, r_z, r_w, r_scalar, equal_flag, zero_divisor,
      output ready
   );
endinterface

>>> design/v4a_div_step.sv
// one registered quotient-bit step of the four-lane restoring divider
module v4a_div_step (
   input  logic                        clock,
   input  logic                        en,
   input  logic [v4a_pkg::WORD_W-1:0]  dvs,
   input  v4a_pkg::div_lanes_type      d_in,
   output v4a_pkg::div_lanes_type      d_out
);
   import v4a_pkg::*;

   div_lanes_type lanes_ff;
   div_lanes_type lanes_in;

   // shift in the next dividend bit, subtract when it fits
   always_comb begin : step_comb
      logic [WORD_W:0] trial;
      logic [WORD_W:0] diff;
      logic            ge;
      lanes_in = d_in;
      for (int i = 0; i < LANES; i++) begin
         trial = {d_in.rem[i], d_in.nlo[i][WORD_W-1]};
         diff  = trial - {1'b0, dvs};
         ge    = (trial >= {1'b0, dvs});
         lanes_in.rem[i] = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
         lanes_in.nlo[i] = {d_in.nlo[i][WORD_W-2:0], 1'b0};
         lanes_in.quo[i] = {d_in.quo[i][WORD_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lanes_ff <= lanes_in;
      end
   end

   assign d_out = lanes_ff;

endmodule

>>> design/vector4_alu.sv
// Vector ALU for 4-tuples in signed fixed point (FRAC_BITS fraction bits):
// compare, add, sub, multiply, negate, scale, divide, magnitude, normalize,
// dot, cross and reflect, all saturating. The unit is fully pipelined and
// takes one item per cycle while the skid buffer is empty; every item runs
// through the same registers, whatever its operation. An item passes through
// 74 registers: 7 front stages (input register, multipliers, sums,
// reflect), 32 square root stages (one root bit each), one divider setup
// stage, 32 divider stages (one quotient bit each) and the final and output
// registers. The input register loads at the accepting edge itself. A
// one-entry skid buffer after the output register lets the pipeline stall
// cleanly; req_bus.ready comes straight from a register.
module vector4_alu #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [v4a_pkg::TOL_W-1:0]  csr_wdata,
   v4a_req_if.sink                    req_bus,
   v4a_rsp_if.source                  rsp_bus
);
   import v4a_pkg::*;

   localparam int unsigned FRONT_STAGES = 7;
   localparam int unsigned SQ_STEPS     = WORD_W;
   localparam int unsigned DIV_STEPS    = WORD_W;
   localparam int unsigned PIPE_DEPTH   = FRONT_STAGES + SQ_STEPS + 1 + DIV_STEPS + 1;

   typedef struct {
      op_type             op;
      word_type           a [LANES];
      word_type           b [LANES];
      word_type           s;
      logic               eq;
      word_type           res [LANES];
      word_type           rs;
      word_type           m [LANES];
      word_type           q [LANES];
      word_type           d;
      logic signed [63:0] p [LANES];
      logic signed [63:0] c [6];
      logic signed [65:0] cd [3];
      logic signed [65:0] dsum;
   } front_type;

   typedef struct {
      op_type      op;
      word_type    a [LANES];
      word_type    s;
      logic        eq;
      word_type    res [LANES];
      word_type    rs;
      logic [63:0] n;
      logic [63:0] root;
   } sq_type;

   typedef struct {
      op_type              op;
      word_type            a [LANES];
      logic                eq;
      word_type            res [LANES];
      word_type            rs;
      logic                zd;
      logic                neg [LANES];
      logic                ovf [LANES];
      logic [WORD_W-1:0]   dvs;
   } dsb_type;

   typedef struct {
      op_type   op;
      word_type r [LANES];
      word_type rs;
      logic     eq;
      logic     zd;
   } res_type;

   logic                  adv;
   logic [TOL_W-1:0]      tol_ff;
   logic [PIPE_DEPTH-1:0] vld_ff;

   front_type             fr_ff [FRONT_STAGES];
   front_type             fr_in [FRONT_STAGES];
   sq_type                sq_ff [SQ_STEPS];
   sq_type                sq_in [SQ_STEPS];
   sq_type                sq_src [SQ_STEPS];
   dsb_type               dsb_ff [DIV_STEPS+1];
   dsb_type               dsb_in;
   div_lanes_type         ln_prep_in;
   div_lanes_type         ln_prep_ff;
   div_lanes_type         ln [DIV_STEPS+1];
   res_type               fin_in;
   res_type               fin_ff;
   res_type               out_ff;
   res_type               skid_ff;
   logic                  out_v_ff;
   logic                  skid_v_ff;
   logic                  take;
   logic                  push;

   // tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_W'(1);
      end else if (csr_we) begin
         tol_ff <= csr_wdata;
      end
   end

   // the whole pipeline moves unless the skid buffer holds an item
   assign adv           = !skid_v_ff;
   assign req_bus.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_bus.valid};
      end
   end

   // input register
   always_comb begin
      fr_in[0]      = fr_ff[0];
      fr_in[0].op   = op_type'(req_bus.req_type);
      fr_in[0].a[0] = req_bus.a_x;
      fr_in[0].a[1] = req_bus.a_y;
      fr_in[0].a[2] = req_bus.a_z;
      fr_in[0].a[3] = req_bus.a_w;
      fr_in[0].b[0] = req_bus.b_x;
      fr_in[0].b[1] = req_bus.b_y;
      fr_in[0].b[2] = req_bus.b_z;
      fr_in[0].b[3] = req_bus.b_w;
      fr_in[0].s    = req_bus.scalar_in;
   end

   // products, simple lane ops and the tolerance compare
   always_comb begin : st1_comb
      logic signed [32:0] diff;
      logic [32:0]        absd;
      logic               ok;
      word_type           xsel;
      fr_in[1]    = fr_ff[0];
      fr_in[1].rs = '0;
      ok = (fr_ff[0].a[3] == fr_ff[0].b[3]);
      for (int i = 0; i < 3; i++) begin
         diff = 33'(fr_ff[0].a[i]) - 33'(fr_ff[0].b[i]);
         absd = diff[32] ? 33'(-diff) : 33'(diff);
         ok   = ok & (absd < 33'(tol_ff));
      end
      fr_in[1].eq = (fr_ff[0].op == OP_CMP) && ok;
      for (int i = 0; i < LANES; i++) begin
         if (fr_ff[0].op == OP_SCALE) begin
            xsel = fr_ff[0].s;
         end else if (fr_ff[0].op inside {OP_MAG, OP_NORM}) begin
            xsel = fr_ff[0].a[i];
         end else begin
            xsel = fr_ff[0].b[i];
         end
         fr_in[1].p[i] = fr_ff[0].a[i] * xsel;
         fr_in[1].m[i] = sat_word(66'(fr_ff[0].b[i]) <<< 1);
         case (fr_ff[0].op)
            OP_ADD: begin
               fr_in[1].res[i] = sat_word(66'(fr_ff[0].a[i]) + 66'(fr_ff[0].b[i]));
            end
            OP_SUB: begin
               fr_in[1].res[i] = sat_word(66'(fr_ff[0].a[i]) - 66'(fr_ff[0].b[i]));
            end
            OP_NEG: begin
               fr_in[1].res[i] = sat_word(-66'(fr_ff[0].a[i]));
            end
            default: begin
               fr_in[1].res[i] = '0;
            end
         endcase
      end
      fr_in[1].c[0] = fr_ff[0].a[1] * fr_ff[0].b[2];
      fr_in[1].c[1] = fr_ff[0].a[2] * fr_ff[0].b[1];
      fr_in[1].c[2] = fr_ff[0].a[2] * fr_ff[0].b[0];
      fr_in[1].c[3] = fr_ff[0].a[0] * fr_ff[0].b[2];
      fr_in[1].c[4] = fr_ff[0].a[0] * fr_ff[0].b[1];
      fr_in[1].c[5] = fr_ff[0].a[1] * fr_ff[0].b[0];
   end

   // product scaling, dot sum and cross differences
   always_comb begin
      fr_in[2] = fr_ff[1];
      for (int i = 0; i < LANES; i++) begin
         if (fr_ff[1].op inside {OP_MUL, OP_SCALE}) begin
            fr_in[2].res[i] = sat_word(66'(fr_ff[1].p[i] >>> FRAC_BITS));
         end
      end
      fr_in[2].dsum = 66'(fr_ff[1].p[0]) + 66'(fr_ff[1].p[1]) + 66'(fr_ff[1].p[2]);
      for (int j = 0; j < 3; j++) begin
         fr_in[2].cd[j] = 66'(fr_ff[1].c[2*j]) - 66'(fr_ff[1].c[2*j+1]);
      end
   end

   // cross result and saturated dot
   always_comb begin
      fr_in[3]   = fr_ff[2];
      fr_in[3].d = sat_word(fr_ff[2].dsum >>> FRAC_BITS);
      if (fr_ff[2].op == OP_CROSS) begin
         for (int j = 0; j < 3; j++) begin
            fr_in[3].res[j] = sat_word(fr_ff[2].cd[j] >>> FRAC_BITS);
         end
         fr_in[3].res[3] = '0;
      end
      if (fr_ff[2].op == OP_DOT) begin
         fr_in[3].rs = sat_word(fr_ff[2].dsum >>> FRAC_BITS);
      end
   end

   // reflect: 2b times dot
   always_comb begin
      fr_in[4] = fr_ff[3];
      for (int i = 0; i < LANES; i++) begin
         fr_in[4].p[i] = fr_ff[3].m[i] * fr_ff[3].d;
      end
   end

   // reflect: scale the product
   always_comb begin
      fr_in[5] = fr_ff[4];
      for (int i = 0; i < LANES; i++) begin
         fr_in[5].q[i] = sat_word(66'(fr_ff[4].p[i] >>> FRAC_BITS));
      end
   end

   // reflect: subtract from a
   always_comb begin
      fr_in[6] = fr_ff[5];
      if (fr_ff[5].op == OP_REFLECT) begin
         for (int i = 0; i < LANES; i++) begin
            fr_in[6].res[i] = sat_word(66'(fr_ff[5].a[i]) - 66'(fr_ff[5].q[i]));
         end
         fr_in[6].rs = fr_ff[5].d;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fr_ff <= fr_in;
      end
   end

   // square root head: radicand is the sum of squares
   always_comb begin
      sq_src[0].op   = fr_ff[FRONT_STAGES-1].op;
      sq_src[0].a    = fr_ff[FRONT_STAGES-1].a;
      sq_src[0].s    = fr_ff[FRONT_STAGES-1].s;
      sq_src[0].eq   = fr_ff[FRONT_STAGES-1].eq;
      sq_src[0].res  = fr_ff[FRONT_STAGES-1].res;
      sq_src[0].rs   = fr_ff[FRONT_STAGES-1].rs;
      sq_src[0].n    = fr_ff[FRONT_STAGES-1].dsum[63:0];
      sq_src[0].root = '0;
   end

   // square root: one root bit per stage
   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
      localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2*k);
      if (k > 0) begin : g_link
         assign sq_src[k] = sq_ff[k-1];
      end
      always_comb begin : sq_comb
         logic [63:0] trial;
         trial    = sq_src[k].root + SQ_BIT;
         sq_in[k] = sq_src[k];
         if (sq_src[k].n >= trial) begin
            sq_in[k].n    = sq_src[k].n - trial;
            sq_in[k].root = (sq_src[k].root >> 1) + SQ_BIT;
         end else begin
            sq_in[k].root = sq_src[k].root >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff <= sq_in;
      end
   end

   // divider setup: divisor, signs, overflow check, first remainder
   always_comb begin : prep_comb
      logic [WORD_W-1:0] mag;
      logic [WORD_W-1:0] abss;
      logic [WORD_W-1:0] absa;
      logic [63:0]       nfull;
      logic              isdiv;
      logic              dneg;
      mag   = sq_ff[SQ_STEPS-1].root[WORD_W-1:0];
      isdiv = (sq_ff[SQ_STEPS-1].op == OP_DIV);
      abss  = sq_ff[SQ_STEPS-1].s[WORD_W-1] ? (~sq_ff[SQ_STEPS-1].s + 32'd1)
                                            : sq_ff[SQ_STEPS-1].s;
      dneg  = isdiv & sq_ff[SQ_STEPS-1].s[WORD_W-1];
      dsb_in.op  = sq_ff[SQ_STEPS-1].op;
      dsb_in.a   = sq_ff[SQ_STEPS-1].a;
      dsb_in.eq  = sq_ff[SQ_STEPS-1].eq;
      dsb_in.res = sq_ff[SQ_STEPS-1].res;
      dsb_in.dvs = isdiv ? abss : mag;
      dsb_in.zd  = (sq_ff[SQ_STEPS-1].op inside {OP_DIV, OP_NORM}) && (dsb_in.dvs == '0);
      if (sq_ff[SQ_STEPS-1].op == OP_MAG) begin
         dsb_in.rs = sat_word(66'(mag));
      end else if (sq_ff[SQ_STEPS-1].op == OP_NORM) begin
         dsb_in.rs = dsb_in.zd ? '0 : sat_word(66'(mag));
      end else begin
         dsb_in.rs = sq_ff[SQ_STEPS-1].rs;
      end
      for (int i = 0; i < LANES; i++) begin
         absa  = sq_ff[SQ_STEPS-1].a[i][WORD_W-1] ? (~sq_ff[SQ_STEPS-1].a[i] + 32'd1)
                                                  : sq_ff[SQ_STEPS-1].a[i];
         nfull = 64'(absa) << FRAC_BITS;
         dsb_in.neg[i]     = sq_ff[SQ_STEPS-1].a[i][WORD_W-1] ^ dneg;
         dsb_in.ovf[i]     = (nfull[63:32] >= dsb_in.dvs);
         ln_prep_in.rem[i] = nfull[63:32];
         ln_prep_in.nlo[i] = nfull[31:0];
         ln_prep_in.quo[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dsb_ff[0]  <= dsb_in;
         ln_prep_ff <= ln_prep_in;
         for (int k = 0; k < DIV_STEPS; k++) begin
            dsb_ff[k+1] <= dsb_ff[k];
         end
      end
   end

   assign ln[0] = ln_prep_ff;

   // divider: one quotient bit per stage
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      v4a_div_step u_step (
         .clock (clock),
         .en    (adv),
         .dvs   (dsb_ff[k].dvs),
         .d_in  (ln[k]),
         .d_out (ln[k+1])
      );
   end

   // quotient sign and saturation, final selection
   always_comb begin : fin_comb
      logic [WORD_W-1:0] qv;
      fin_in.op = dsb_ff[DIV_STEPS].op;
      fin_in.r  = dsb_ff[DIV_STEPS].res;
      fin_in.rs = dsb_ff[DIV_STEPS].rs;
      fin_in.eq = dsb_ff[DIV_STEPS].eq;
      fin_in.zd = dsb_ff[DIV_STEPS].zd;
      for (int i = 0; i < LANES; i++) begin
         qv = ln[DIV_STEPS].quo[i];
         if (dsb_ff[DIV_STEPS].op inside {OP_DIV, OP_NORM}) begin
            if (dsb_ff[DIV_STEPS].zd) begin
               fin_in.r[i] = dsb_ff[DIV_STEPS].a[i];
            end else if (dsb_ff[DIV_STEPS].neg[i]) begin
               if (dsb_ff[DIV_STEPS].ovf[i] || (qv > 32'h8000_0000)) begin
                  fin_in.r[i] = WORD_MIN;
               end else begin
                  fin_in.r[i] = word_type'(~qv + 32'd1);
               end
            end else begin
               if (dsb_ff[DIV_STEPS].ovf[i] || (qv > 32'h7FFF_FFFF)) begin
                  fin_in.r[i] = WORD_MAX;
               end else begin
                  fin_in.r[i] = word_type'(qv);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fin_ff <= fin_in;
      end
   end

   // output register with one-entry skid buffer
   assign take = !out_v_ff || rsp_bus.ready;
   assign push = adv && vld_ff[PIPE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (take) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end
      end else if (push) begin
         if (take) begin
            out_v_ff <= 1'b1;
         end else begin
            skid_v_ff <= 1'b1;
         end
      end else if (take) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (take) begin
            out_ff <= fin_ff;
         end else begin
            skid_ff <= fin_ff;
         end
      end
   end

   assign rsp_bus.valid        = out_v_ff;
   assign rsp_bus.r_x          = out_ff.r[0];
   assign rsp_bus.r_y          = out_ff.r[1];
   assign rsp_bus.r_z          = out_ff.r[2];
   assign rsp_bus.r_w          = out_ff.r[3];
   assign rsp_bus.r_scalar     = out_ff.rs;
   assign rsp_bus.equal_flag   = out_ff.eq;
   assign rsp_bus.zero_divisor = out_ff.zd;

   // skid buffer only fills behind a held output
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid buffer full while output register empty");

   a_skid_fill_cause : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && !rsp_bus.ready))
      else $error("skid buffer filled without an output stall");

   a_zd_only_div : assert property (@(posedge clock) disable iff (reset)
      (vld_ff[PIPE_DEPTH-1] && fin_ff.zd) |-> ((fin_ff.op == OP_DIV) || (fin_ff.op == OP_NORM)))
      else $error("zero divisor flag on an operation without a divide");

   a_cmp_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.equal_flag) |->
         ((rsp_bus.r_x == '0) && (rsp_bus.r_y == '0) && (rsp_bus.r_z == '0) &&
          (rsp_bus.r_w == '0) && (rsp_bus.r_scalar == '0) && !rsp_bus.zero_divisor))
      else $error("compare result carries nonzero fields");

endmodule

>>> bench/tb_vector4_alu.sv
// self-checking testbench for the 4-tuple vector alu with a scoreboard class
module tb_vector4_alu;
   timeunit 1ns;
   timeprecision 1ps;

   import v4a_pkg::*;

   typedef logic signed [69:0] wide_type;

   typedef struct {
      logic [3:0] op;
      word_type   a[4];
      word_type   b[4];
      word_type   s;
   } vec_req_type;

   typedef struct {
      word_type r[4];
      word_type rs;
      logic     eq;
      logic     zd;
   } vec_rsp_type;

   // expected results of the alu, oldest first
   class vec_scoreboard;
      vec_rsp_type pending[$];
      int          errors = 0;

      function word_type clamp(wide_type v);
         if (v > wide_type'(WORD_MAX)) return WORD_MAX;
         if (v < wide_type'(WORD_MIN)) return WORD_MIN;
         return word_type'(v[31:0]);
      endfunction

      function longint unsigned root_floor(longint unsigned n);
         longint unsigned root = 0;
         longint unsigned bitv = 64'd1 << 62;
         while (bitv > n) bitv >>= 2;
         while (bitv != 0) begin
            if (n >= root + bitv) begin
               n -= root + bitv;
               root = (root >> 1) + bitv;
            end else begin
               root >>= 1;
            end
            bitv >>= 2;
         end
         return root;
      endfunction

      function vec_rsp_type compute_vector_result(vec_req_type q, logic [TOL_W-1:0] tol);
         vec_rsp_type res;
         wide_type p, t1, t2, dotv, mag, tl, s70;
         word_type m, d;
         logic ok;
         res.rs = 0;
         res.eq = 0;
         res.zd = 0;
         for (int i = 0; i < 4; i++) res.r[i] = 0;
         s70 = q.s;
         case (q.op)
            OP_CMP: begin
               tl = tol;
               ok = (q.a[3] == q.b[3]);
               for (int i = 0; i < 3; i++) begin
                  p = q.a[i];
                  p = p - q.b[i];
                  if (p < 0) p = -p;
                  if (!(p < tl)) ok = 0;
               end
               res.eq = ok;
            end
            OP_ADD, OP_SUB, OP_NEG: begin
               for (int i = 0; i < 4; i++) begin
                  p = q.a[i];
                  if (q.op == OP_ADD) p = p + q.b[i];
                  else if (q.op == OP_SUB) p = p - q.b[i];
                  else p = -p;
                  res.r[i] = clamp(p);
               end
            end
            OP_MUL, OP_SCALE: begin
               for (int i = 0; i < 4; i++) begin
                  p = q.a[i] * ((q.op == OP_MUL) ? q.b[i] : q.s);
                  res.r[i] = clamp(p >>> 16);
               end
            end
            OP_DIV: begin
               for (int i = 0; i < 4; i++) begin
                  if (q.s == 0) begin
                     res.r[i] = q.a[i];
                  end else begin
                     p = q.a[i];
                     p = (p <<< 16) / s70;
                     res.r[i] = clamp(p);
                  end
               end
               res.zd = (q.s == 0);
            end
            OP_MAG, OP_NORM: begin
               p = q.a[0] * q.a[0];
               t1 = q.a[1] * q.a[1];
               t2 = q.a[2] * q.a[2];
               p = p + t1 + t2;
               mag = wide_type'(root_floor(p[63:0]));
               if (q.op == OP_MAG) begin
                  res.rs = clamp(mag);
               end else if (mag == 0) begin
                  res.zd = 1;
                  for (int i = 0; i < 4; i++) res.r[i] = q.a[i];
               end else begin
                  res.rs = clamp(mag);
                  for (int i = 0; i < 4; i++) begin
                     p = q.a[i];
                     p = (p <<< 16) / mag;
                     res.r[i] = clamp(p);
                  end
               end
            end
            OP_DOT, OP_REFLECT: begin
               dotv = q.a[0] * q.b[0];
               t1 = q.a[1] * q.b[1];
               t2 = q.a[2] * q.b[2];
               dotv = dotv + t1 + t2;
               d = clamp(dotv >>> 16);
               res.rs = d;
               if (q.op == OP_REFLECT) begin
                  for (int i = 0; i < 4; i++) begin
                     p = q.b[i];
                     m = clamp(p * 2);
                     p = m * d;
                     t1 = clamp(p >>> 16);
                     p = q.a[i];
                     res.r[i] = clamp(p - t1);
                  end
               end
            end
            OP_CROSS: begin
               for (int i = 0; i < 3; i++) begin
                  t1 = q.a[(i + 1) % 3] * q.b[(i + 2) % 3];
                  t2 = q.a[(i + 2) % 3] * q.b[(i + 1) % 3];
                  res.r[i] = clamp((t1 - t2) >>> 16);
               end
            end
            default: ;
         endcase
         return res;
      endfunction

      function void note_request(vec_req_type q, logic [TOL_W-1:0] tol);
         pending.push_back(compute_vector_result(q, tol));
      endfunction

      function void check_result(vec_rsp_type got);
         vec_rsp_type want;
         if (pending.size() == 0) begin
            $error("result with no item outstanding");
            errors++;
            return;
         end
         want = pending.pop_front();
         for (int i = 0; i < 4; i++) begin
            if (got.r[i] !== want.r[i]) begin
               $error("r[%0d] expected %0d got %0d", i, want.r[i], got.r[i]);
               errors++;
            end
         end
         if (got.rs !== want.rs) begin
            $error("r_scalar expected %0d got %0d", want.rs, got.rs);
            errors++;
         end
         if (got.eq !== want.eq) begin
            $error("equal_flag expected %0b got %0b", want.eq, got.eq);
            errors++;
         end
         if (got.zd !== want.zd) begin
            $error("zero_divisor expected %0b got %0b", want.zd, got.zd);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [TOL_W-1:0] csr_wdata = 0;
   logic [TOL_W-1:0] tolerance = 1;
   bit quiet = 0;
   vec_scoreboard board = new();

   v4a_req_if req_if();
   v4a_rsp_if rsp_if();

   vector4_alu DUT (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .req_bus(req_if),
      .rsp_bus(rsp_if)
   );

   always #10 clock = ~clock;

   // generous overall limit
   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

   // random word biased toward the extremes and small magnitudes
   function automatic word_type pick_word();
      case ($urandom_range(9))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return 0;
         3, 4: return word_type'($urandom_range(262144)) - 131072;
         default: return word_type'($urandom);
      endcase
   endfunction

   function automatic vec_req_type build(logic [3:0] op, word_type ax, word_type ay,
         word_type az, word_type aw, word_type bx, word_type by, word_type bz,
         word_type bw, word_type s);
      vec_req_type q;
      q.op = op;
      q.a = '{ax, ay, az, aw};
      q.b = '{bx, by, bz, bw};
      q.s = s;
      return q;
   endfunction

   function automatic vec_req_type random_request();
      vec_req_type q;
      q.op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 12)) : 4'($urandom_range(11));
      for (int i = 0; i < 4; i++) begin
         q.a[i] = pick_word();
         q.b[i] = pick_word();
      end
      q.s = pick_word();
      // steer compares near the tolerance, divides and normalizes onto zero
      if (q.op == OP_CMP && $urandom_range(9) < 6) begin
         for (int i = 0; i < 3; i++) q.b[i] = q.a[i] + $urandom_range(140000) - 70000;
         if ($urandom_range(4) != 0) q.b[3] = q.a[3];
      end
      if (q.op == OP_DIV && $urandom_range(6) == 0) q.s = 0;
      if (q.op == OP_NORM && $urandom_range(6) == 0) q.a[0:2] = '{0, 0, 0};
      return q;
   endfunction

   // drive one item and hold it until accepted
   task automatic send_item(vec_req_type q);
      if (!quiet && $urandom_range(99) < 38) begin
         req_if.valid <= 0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_if.valid <= 1;
      req_if.req_type <= q.op;
      req_if.a_x <= q.a[0];
      req_if.a_y <= q.a[1];
      req_if.a_z <= q.a[2];
      req_if.a_w <= q.a[3];
      req_if.b_x <= q.b[0];
      req_if.b_y <= q.b[1];
      req_if.b_z <= q.b[2];
      req_if.b_w <= q.b[3];
      req_if.scalar_in <= q.s;
      do @(posedge clock); while (!req_if.ready);
      board.note_request(q, tolerance);
   endtask

   // let the pipeline drain, then write the tolerance
   task automatic write_tolerance(logic [TOL_W-1:0] v);
      req_if.valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      tolerance = v;
   endtask

   // result side: check accepted items, stall at random
   initial begin
      vec_rsp_type got;
      rsp_if.ready = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got.r = '{rsp_if.r_x, rsp_if.r_y, rsp_if.r_z, rsp_if.r_w};
            got.rs = rsp_if.r_scalar;
            got.eq = rsp_if.equal_flag;
            got.zd = rsp_if.zero_divisor;
            board.check_result(got);
         end
         rsp_if.ready <= quiet || ($urandom_range(99) >= 38);
      end
   end

   // stimulus
   initial begin
      logic [TOL_W-1:0] settings[4];
      req_if.valid = 0;
      req_if.req_type = 0;
      req_if.a_x = 0;
      req_if.a_y = 0;
      req_if.a_z = 0;
      req_if.a_w = 0;
      req_if.b_x = 0;
      req_if.b_y = 0;
      req_if.b_z = 0;
      req_if.b_w = 0;
      req_if.scalar_in = 0;
      repeat (11) @(posedge clock);
      reset <= 0;

      // directed items under the reset tolerance
      send_item(build(OP_CMP, 5, 6, 7, 8, 5, 6, 7, 8, 0));
      send_item(build(OP_CMP, 5, 6, 7, 8, 6, 6, 7, 8, 0));
      send_item(build(OP_CMP, 5, 6, 7, 8, 5, 6, 7, 9, 0));
      send_item(build(OP_CMP, WORD_MAX, 0, 0, 0, WORD_MIN, 0, 0, 0, 0));
      send_item(build(OP_ADD, WORD_MAX, WORD_MIN, 1, -1, 1, -1, 2, 3, 0));
      send_item(build(OP_SUB, WORD_MIN, WORD_MAX, 0, 5, 1, -1, WORD_MIN, 7, 0));
      send_item(build(OP_MUL, WORD_MAX, WORD_MIN, -1, 65536, WORD_MAX, WORD_MIN, 1, -3, 0));
      send_item(build(OP_NEG, WORD_MIN, WORD_MAX, 0, -1, 0, 0, 0, 0, 0));
      send_item(build(OP_SCALE, 65536, -65536, WORD_MAX, -1, 0, 0, 0, 0, WORD_MIN));
      send_item(build(OP_DIV, 65536, -3, WORD_MIN, WORD_MAX, 0, 0, 0, 0, 0));
      send_item(build(OP_DIV, WORD_MIN, 7, -7, WORD_MAX, 0, 0, 0, 0, -1));
      send_item(build(OP_DIV, 65536, -65536, 3, 1, 0, 0, 0, 0, 1));
      send_item(build(OP_MAG, WORD_MIN, WORD_MIN, WORD_MIN, 9, 0, 0, 0, 0, 0));
      send_item(build(OP_MAG, 196608, 262144, 0, 0, 0, 0, 0, 0, 0));
      send_item(build(OP_NORM, 0, 0, 0, 12345, 0, 0, 0, 0, 0));
      send_item(build(OP_NORM, 0, 0, 1, WORD_MIN, 0, 0, 0, 0, 0));
      send_item(build(OP_NORM, WORD_MIN, WORD_MAX, 3, WORD_MAX, 0, 0, 0, 0, 0));
      send_item(build(OP_DOT, WORD_MIN, WORD_MIN, WORD_MIN, 0, WORD_MIN, WORD_MIN,
         WORD_MIN, 0, 0));
      send_item(build(OP_DOT, -1, 0, 0, 0, 1, 0, 0, 0, 0));
      send_item(build(OP_CROSS, WORD_MIN, WORD_MAX, WORD_MIN, 7, WORD_MAX, WORD_MIN,
         WORD_MAX, 9, 0));
      send_item(build(OP_CROSS, 65536, 0, 0, 4, 0, 65536, 0, 5, 0));
      send_item(build(OP_REFLECT, WORD_MAX, WORD_MIN, 65536, -1, WORD_MAX, WORD_MIN,
         65536, WORD_MIN, 0));
      send_item(build(OP_REFLECT, 65536, -65536, 0, 0, 0, 65536, 0, 0, 0));
      send_item(build(4'd12, 1, 2, 3, 4, 5, 6, 7, 8, 9));
      send_item(build(4'd15, -1, -1, -1, -1, -1, -1, -1, -1, -1));

      // random phases over several tolerance settings
      settings = '{0, 65536, 131071, 17'($urandom_range(70000))};
      for (int ph = 0; ph < 4; ph++) begin
         write_tolerance(settings[ph]);
         for (int n = 0; n < 375; n++) begin
            quiet = (ph == 1 && n >= 100 && n < 300);
            send_item(random_request());
         end
         quiet = 0;
      end
      req_if.valid <= 0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (board.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
